>>> hdl/rmqr_pkg.sv
// shared types and constants for the range minimum query and raise block
package rmqr_pkg;

	localparam int DATA_W = 32;
	localparam int BEGIN_W = 11;
	localparam int END_W = 12;
	localparam int ACT_W = 2;
	localparam int IN_TDATA_W = 56;

	typedef enum logic [ACT_W-1:0] {
		ACT_QUERY = 2'd0,
		ACT_RAISE = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef logic signed [DATA_W-1:0] height_t;

endpackage

>>> hdl/rmqr_mem.sv
// height table: one write port, one registered read port
module rmqr_mem
	import rmqr_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  height_t       wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output height_t       rdata
);

	height_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/rmqr_cmp.sv
// shared signed compare unit for both minimum search and raise
module rmqr_cmp
	import rmqr_pkg::*;
(
	input  height_t a,
	input  height_t b,
	output logic    lt
);

	assign lt = a < b;

endmodule

>>> hdl/range_min_query_and_raise_top.sv
// top level: sequencer walking the height table through one shared compare unit
//
// The table holds TABLE_DEPTH signed 32-bit heights in a single-port-read,
// single-port-write memory, walked one entry per cycle. After reset the block
// runs a clearing pass with s_tready low; a clear beat runs the same pass. A
// query over n entries (n at least one, the begin entry alone for an empty or
// reversed range) walks them and drains the last read before the result is
// loaded into the output register, and waits while that register is still held
// by an untaken result; a query whose begin lies past the table answers zero. A
// raise over n entries walks them; an empty raise or unused action returns to
// idle without a walk. The registered memory read sets the pipeline; the table
// depth sets the longest walk per beat. One beat is worked on at a time.
module range_min_query_and_raise_top
	import rmqr_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// range_begin[10:0], range_end[22:11], value[54:23], zero fill above
	input  logic [IN_TDATA_W-1:0] s_tdata,
	// action[1:0]
	input  logic [ACT_W-1:0]      s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// minimum[31:0]
	output logic [DATA_W-1:0]     m_tdata
);

	localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = (AW + 1 > END_W) ? AW + 1 : END_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [AW-1:0] p_q;
	logic [AW-1:0] last_q;
	act_t          act_q;
	height_t       val_q;
	height_t       best_q;
	logic          rd_v_s1;
	logic          first_s1;
	logic [AW-1:0] addr_s1;
	logic          first_q;
	logic          out_valid_q;
	height_t       out_q;

	logic          accept;
	act_t          in_act;
	logic [CW-1:0] beg_x;
	logic [CW-1:0] end_x;
	logic [CW-1:0] end_c;
	logic          beg_in;
	logic          nonempty;
	logic [CW-1:0] end_m1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	height_t       mem_wdata;
	logic          mem_re;
	height_t       rdata;
	height_t       cmp_b;
	logic          lt;

	assign in_act   = act_t'(s_tuser);
	assign beg_x    = CW'(s_tdata[BEGIN_W-1:0]);
	assign end_x    = CW'(s_tdata[BEGIN_W+END_W-1:BEGIN_W]);
	assign end_c    = (end_x > DEPTH_C) ? DEPTH_C : end_x;
	assign beg_in   = beg_x < DEPTH_C;
	assign nonempty = end_c > beg_x;
	assign end_m1   = end_c - CW'(1);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// shared compare: query checks against running minimum, raise against value
	assign cmp_b = (act_q == ACT_QUERY) ? best_q : val_q;

	rmqr_cmp u_cmp (
		.a  (rdata),
		.b  (cmp_b),
		.lt (lt)
	);

	assign mem_re = (state_q == ST_WALK);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = val_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = p_q;
			mem_wdata = '0;
		end else if (rd_v_s1 && act_q == ACT_RAISE && lt) begin
			mem_we = 1'b1;
		end
	end

	rmqr_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (p_q),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (p_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_act)
						ACT_QUERY: state_d = beg_in ? ST_WALK : ST_DONE;
						ACT_RAISE: state_d = (beg_in && nonempty) ? ST_WALK : ST_IDLE;
						ACT_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (p_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (act_q == ACT_QUERY) ? ST_DONE : ST_IDLE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q      <= '0;
			rd_v_s1  <= 1'b0;
			first_q  <= 1'b0;
			first_s1 <= 1'b0;
			act_q    <= ACT_NONE;
		end else begin
			rd_v_s1  <= (state_q == ST_WALK);
			first_s1 <= first_q;
			case (state_q)
				ST_CLEAR: begin
					p_q <= p_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						act_q   <= in_act;
						first_q <= 1'b1;
						if (in_act == ACT_CLEAR) begin
							p_q <= '0;
						end else begin
							p_q <= beg_x[AW-1:0];
						end
					end
				end
				ST_WALK: begin
					first_q <= 1'b0;
					p_q     <= p_q + AW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// walk bounds, raise value, running minimum
	always_ff @(posedge clk) begin
		addr_s1 <= p_q;
		if (accept) begin
			val_q  <= height_t'(s_tdata[BEGIN_W+END_W+DATA_W-1:BEGIN_W+END_W]);
			best_q <= '0;
			last_q <= nonempty ? end_m1[AW-1:0] : beg_x[AW-1:0];
		end else if (rd_v_s1 && act_q == ACT_QUERY && (first_s1 || lt)) begin
			best_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_q <= best_q;
		end
	end

endmodule

>>> test/tb_top.sv
// testbench for the range minimum query and raise block, checked against a behavioural height table
module tb_top;
	import rmqr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 2048;
	localparam int RANDOM_BEATS = 268;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		act_t        act;
		logic [10:0] lo;
		logic [11:0] hi;
		height_t     val;
		logic        typed;
		height_t     want;
	} row_t;

	// directed beats, expected minimum typed in where it is obvious
	localparam row_t SCRIPT [23] = '{
		'{ACT_QUERY, 11'd0,    12'd2048, 32'sd0,         1'b1, 32'sd0},
		'{ACT_QUERY, 11'd2047, 12'd4095, 32'sd0,         1'b1, 32'sd0},
		'{ACT_QUERY, 11'd9,    12'd3,    32'sd0,         1'b1, 32'sd0},
		'{ACT_RAISE, 11'd0,    12'd2048, 32'h7fff_ffff,  1'b0, 32'sd0},
		'{ACT_QUERY, 11'd0,    12'd2048, 32'sd0,         1'b1, 32'h7fff_ffff},
		'{ACT_RAISE, 11'd0,    12'd4095, 32'h8000_0000,  1'b0, 32'sd0},
		'{ACT_QUERY, 11'd1000, 12'd1000, 32'sd0,         1'b1, 32'h7fff_ffff},
		'{ACT_CLEAR, 11'd0,    12'd0,    32'sd0,         1'b0, 32'sd0},
		'{ACT_QUERY, 11'd0,    12'd2048, 32'sd0,         1'b1, 32'sd0},
		'{ACT_RAISE, 11'd10,   12'd20,   32'sd100,       1'b0, 32'sd0},
		'{ACT_RAISE, 11'd15,   12'd30,   -32'sd7,        1'b0, 32'sd0},
		'{ACT_RAISE, 11'd18,   12'd25,   32'sd250,       1'b0, 32'sd0},
		'{ACT_QUERY, 11'd5,    12'd25,   32'sd0,         1'b0, 32'sd0},
		'{ACT_QUERY, 11'd10,   12'd20,   32'sd0,         1'b0, 32'sd0},
		'{ACT_QUERY, 11'd18,   12'd25,   32'sd0,         1'b0, 32'sd0},
		'{ACT_QUERY, 11'd20,   12'd12,   32'sd0,         1'b0, 32'sd0},
		'{ACT_NONE,  11'd0,    12'd2048, 32'sd555,       1'b0, 32'sd0},
		'{ACT_QUERY, 11'd10,   12'd11,   32'sd0,         1'b0, 32'sd0},
		'{ACT_RAISE, 11'd2047, 12'd4095, 32'h0000_ffff,  1'b0, 32'sd0},
		'{ACT_QUERY, 11'd2040, 12'd2048, 32'sd0,         1'b0, 32'sd0},
		'{ACT_QUERY, 11'd2047, 12'd2048, 32'sd0,         1'b0, 32'sd0},
		'{ACT_RAISE, 11'd0,    12'd1,    32'sd1,         1'b0, 32'sd0},
		'{ACT_QUERY, 11'd0,    12'd0,    32'sd0,         1'b0, 32'sd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_W-1:0]     m_tdata;

	height_t     heights [TABLE_DEPTH];
	height_t     minima_due [$];
	height_t     due;
	int unsigned send_idle_pct = 13;
	int unsigned recv_idle_pct = 80;
	bit          hold_req = 1'b0;
	int unsigned err_count = 0;
	int unsigned queries_sent = 0;
	int unsigned raises_sent = 0;
	int unsigned clears_sent = 0;
	int unsigned ignored_sent = 0;
	int unsigned minima_seen = 0;
	int unsigned window_lo = 0;

	range_min_query_and_raise_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("timeout with %0d minima outstanding", minima_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		err_count++;
	endtask

	// applies one beat to the height table, returns 1 when a minimum is due
	function automatic bit step_heights(input act_t act, input logic [10:0] lo,
			input logic [11:0] hi, input height_t val, output height_t least);
		int unsigned last;
		last = (int'(hi) > TABLE_DEPTH) ? TABLE_DEPTH : int'(hi);
		least = '0;
		case (act)
			ACT_QUERY: begin
				if (lo < TABLE_DEPTH) begin
					least = heights[lo];
					for (int p = int'(lo); p < last; p++)
						if (heights[p] < least)
							least = heights[p];
				end
				return 1'b1;
			end
			ACT_RAISE: begin
				if (lo < TABLE_DEPTH)
					for (int p = int'(lo); p < last; p++)
						if (heights[p] < val)
							heights[p] = val;
			end
			ACT_CLEAR: begin
				for (int p = 0; p < TABLE_DEPTH; p++)
					heights[p] = '0;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send_beat(input act_t act, input logic [10:0] lo, input logic [11:0] hi,
			input height_t val, input bit typed, input height_t want);
		height_t least;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, val, hi, lo};
		do @(posedge clk); while (!s_tready);
		if (step_heights(act, lo, hi, val, least))
			minima_due.push_back(typed ? want : least);
		case (act)
			ACT_QUERY: queries_sent++;
			ACT_RAISE: raises_sent++;
			ACT_CLEAR: clears_sent++;
			default:   ignored_sent++;
		endcase
	endtask

	// mostly short ranges inside a moving window so raises and queries overlap
	task automatic random_beat(output bit counted);
		act_t        act;
		int unsigned pick;
		int unsigned lo;
		int unsigned hi;
		height_t     val;
		pick = $urandom_range(99);
		if (pick < 46)
			act = ACT_QUERY;
		else if (pick < 93)
			act = ACT_RAISE;
		else if (pick < 95)
			act = ACT_CLEAR;
		else
			act = ACT_NONE;
		if ($urandom_range(99) < 75)
			lo = window_lo + $urandom_range(127);
		else
			lo = $urandom_range(TABLE_DEPTH - 1);
		pick = $urandom_range(99);
		if (pick < 6)
			hi = $urandom_range(4095, lo);
		else if (pick < 14)
			hi = $urandom_range(lo);
		else
			hi = lo + $urandom_range(48);
		pick = $urandom_range(99);
		if (pick < 60)
			val = height_t'($urandom_range(5000));
		else if (pick < 80)
			val = height_t'($urandom);
		else
			val = -height_t'($urandom_range(100000));
		send_beat(act, lo[10:0], hi[11:0], val, 1'b0, '0);
		counted = (act != ACT_NONE);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			minima_seen++;
			if (minima_due.size() == 0) begin
				flag_mismatch($sformatf("minimum %0d with none due", $signed(m_tdata)));
			end else begin
				due = minima_due.pop_front();
				if (m_tdata !== due)
					flag_mismatch($sformatf("minimum %0d, due %0d", $signed(m_tdata), due));
			end
		end
	end

	initial begin
		int unsigned sent;
		bit          counted;
		sent = 0;
		for (int p = 0; p < TABLE_DEPTH; p++)
			heights[p] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (SCRIPT[r])
			send_beat(SCRIPT[r].act, SCRIPT[r].lo, SCRIPT[r].hi, SCRIPT[r].val,
				SCRIPT[r].typed, SCRIPT[r].want);

		window_lo = $urandom_range(TABLE_DEPTH - 128);
		while (sent < RANDOM_BEATS) begin
			if (sent == RANDOM_BEATS / 3) begin
				send_idle_pct = 80;
				recv_idle_pct = 13;
				window_lo = $urandom_range(TABLE_DEPTH - 128);
			end else if (sent == 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = 1'b1;
				window_lo = $urandom_range(TABLE_DEPTH - 128);
			end
			random_beat(counted);
			if (counted)
				sent++;
		end
		s_tvalid <= 1'b0;

		while (minima_due.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("beats: %0d queries, %0d raises, %0d clears, %0d unused action",
			queries_sent, raises_sent, clears_sent, ignored_sent);
		$display("minima checked: %0d, mismatches: %0d", minima_seen, err_count);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
hdl/rmqr_pkg.sv
hdl/rmqr_mem.sv
hdl/rmqr_cmp.sv
hdl/range_min_query_and_raise_top.sv
test/tb_top.sv
